FILE: design/kpsde_pkg.sv
// ----------------------------------------------------------------------------
// kpsde_pkg
// Shared types, sizes and the key character table for the keypad scanner.
// ----------------------------------------------------------------------------
package kpsde_pkg;

	localparam int COLUMNS_DEF = 3;
	localparam int ROWS_DEF    = 4;

	localparam int POS_W       = 3;
	localparam int FULL_IDX_W  = 8;
	localparam int KEY_IDX_W   = 4;
	localparam int KEY_CHAR_W  = 7;
	localparam int OUT_TDATA_W = 16;
	localparam int CHAR_COUNT  = 12;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} lane_hit_t;

	localparam logic [KEY_CHAR_W-1:0] KEY_CHARS [CHAR_COUNT] = '{
		7'h31, 7'h34, 7'h37, 7'h2a,
		7'h32, 7'h35, 7'h38, 7'h30,
		7'h33, 7'h36, 7'h39, 7'h23
	};

	function automatic logic [KEY_CHAR_W-1:0] key_char(input logic [FULL_IDX_W-1:0] idx);
		logic [KEY_CHAR_W-1:0] ch;
		ch = '0;
		if (idx < FULL_IDX_W'(CHAR_COUNT)) begin
			ch = KEY_CHARS[idx[3:0]];
		end
		return ch;
	endfunction

endpackage

FILE: design/kpsde_lane.sv
// ----------------------------------------------------------------------------
// kpsde_lane
// One column: lowest-row filter, stability match, rising-edge detect and
// highest-row pick of the rise bits.
// ----------------------------------------------------------------------------
module kpsde_lane #(
	parameter int ROWS = kpsde_pkg::ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ROWS-1:0]      rows,
	input  logic                 accept,
	input  logic                 stable,
	output logic                 eq,
	output kpsde_pkg::lane_hit_t hit_s1
);

	logic [ROWS-1:0]      cur;
	logic [ROWS-1:0]      rise;
	logic [ROWS-1:0]      prev_q;
	logic [ROWS-1:0]      last_q;
	kpsde_pkg::lane_hit_t hit;

	assign cur  = rows & (~rows + ROWS'(1));
	assign eq   = (cur != '0) && (cur == last_q);
	assign rise = stable ? (cur & ~prev_q) : '0;

	always_comb begin
		hit = '0;
		for (int r = 0; r < ROWS; r++) begin
			if (rise[r]) begin
				hit.hit = 1'b1;
				hit.pos = kpsde_pkg::POS_W'(ROWS - 1 - r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			last_q <= '0;
		end else if (accept) begin
			last_q <= cur;
			prev_q <= stable ? cur : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= hit;
		end
	end

	a_prev_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_q == '0) || (prev_q == last_q))
		else $error("edge reference out of step with last scan");

	a_last_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(last_q) <= 1)
		else $error("filtered column holds more than one row");

endmodule

FILE: design/kpsde_merge.sv
// ----------------------------------------------------------------------------
// kpsde_merge
// Picks the first column with a rising key, forms index and character, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module kpsde_merge #(
	parameter int COLUMNS = kpsde_pkg::COLUMNS_DEF,
	parameter int ROWS    = kpsde_pkg::ROWS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  kpsde_pkg::lane_hit_t [COLUMNS-1:0]   lanes,
	output logic                                 adv,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [kpsde_pkg::OUT_TDATA_W-1:0]    m_tdata,  // key_index, key_char
	output logic                                 m_tuser   // press_valid
);

	logic                                found;
	logic [kpsde_pkg::FULL_IDX_W-1:0]    idx;
	logic                                out_v_q;
	logic                                press_q;
	logic [kpsde_pkg::KEY_IDX_W-1:0]     idx_q;
	logic [kpsde_pkg::KEY_CHAR_W-1:0]    char_q;

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int c = COLUMNS - 1; c >= 0; c--) begin
			if (lanes[c].hit) begin
				found = 1'b1;
				idx   = kpsde_pkg::FULL_IDX_W'(c * ROWS) +
				        kpsde_pkg::FULL_IDX_W'(lanes[c].pos);
			end
		end
	end

	assign adv = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			press_q <= found;
			idx_q   <= found ? idx[kpsde_pkg::KEY_IDX_W-1:0] : '0;
			char_q  <= found ? kpsde_pkg::key_char(idx) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = press_q;
	assign m_tdata  = {{(kpsde_pkg::OUT_TDATA_W - kpsde_pkg::KEY_IDX_W -
	                     kpsde_pkg::KEY_CHAR_W){1'b0}}, char_q, idx_q};

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("no-press result carries nonzero data");

	a_press_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_valid |=> m_tvalid && (m_tuser == $past(found)))
		else $error("press flag lost on load");

endmodule

FILE: design/keypad_scan_debounce_edge_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce_edge_unit
// Debounced key press detector for a matrix keypad, one scan per request.
// ----------------------------------------------------------------------------
// Takes one scan request per clock while s_tready is high and returns one
// result per request: one register stage holds each column's hit and row
// position, the output register holds the merged result. Each column has
// its own lane with its filter and edge state; a merge stage picks the first
// rising key in table order. Throughput is set by the output register, which
// frees when empty or taken by the sink, so scans can follow back to back.
module keypad_scan_debounce_edge_unit #(
	parameter int COLUMNS = kpsde_pkg::COLUMNS_DEF,
	parameter int ROWS    = kpsde_pkg::ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((COLUMNS*ROWS+7)/8)*8-1:0] s_tdata,  // col0_rows, col1_rows, ...
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [kpsde_pkg::OUT_TDATA_W-1:0] m_tdata,  // key_index, key_char
	output logic                              m_tuser   // press_valid
);

	logic                               accept;
	logic                               adv;
	logic                               stable;
	logic [COLUMNS-1:0]                 eq;
	logic                               v_s1;
	kpsde_pkg::lane_hit_t [COLUMNS-1:0] hit_s1;

	assign s_tready = !v_s1 || adv;
	assign accept   = s_tvalid && s_tready;
	assign stable   = |eq;

	for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
		kpsde_lane #(
			.ROWS(ROWS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.rows   (s_tdata[c*ROWS +: ROWS]),
			.accept (accept),
			.stable (stable),
			.eq     (eq[c]),
			.hit_s1 (hit_s1[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	kpsde_merge #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.lanes    (hit_s1),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
